// File: rtl/core/mpm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mpm_pkg
// Shared types, constants and helpers of the Mandelbrot pixel membership test.
// ============================================================================
package mpm_pkg;

    // Default parameter values.
    localparam int MAX_ITER_DEF    = 50;
    localparam int COORD_BITS_DEF  = 12;

    // Field widths fixed by the interface.
    localparam int PIX_W  = 12;
    localparam int DIM_W  = 13;
    localparam int Q_W    = 32;
    localparam int SPAN_W = 30;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Window constants in Q4.28.
    localparam logic signed [Q_W-1:0] RE_MIN  = -32'sd671088640;
    localparam logic signed [Q_W-1:0] IM_MIN  = -32'sd268435456;
    localparam logic [SPAN_W-1:0]     RE_SPAN = 30'd939524096;
    localparam logic [SPAN_W-1:0]     IM_SPAN = 30'd536870912;
    localparam logic signed [Q_W-1:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [Q_W-1:0] Q_MIN   = 32'sh8000_0000;

    // Escape bound 4.0 in Q8.56.
    localparam logic [63:0] ESC_BOUND = 64'h0400_0000_0000_0000;

    // Reset values of the dimension registers.
    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    // State of one pixel between iterations.
    typedef struct packed {
        logic signed [Q_W-1:0] zr;
        logic signed [Q_W-1:0] zi;
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
        logic                  esc;
    } t_iter;

    // Saturate a widened sum to the Q4.28 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [37:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 38'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < 38'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/mpm_pix_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mpm_pix_if
// Pixel coordinate channel with valid/ready handshake.
// ============================================================================
interface mpm_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] column;
    logic [11:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

// File: rtl/core/mpm_res_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mpm_res_if
// Membership result channel with valid/ready handshake.
// ============================================================================
interface mpm_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_column;
    logic [11:0] out_row;
    logic        inside_res;

    modport source (output valid, output out_column, output out_row,
                    output inside_res, input ready);
    modport sink   (input valid, input out_column, input out_row,
                    input inside_res, output ready);
endinterface

// File: rtl/core/mpm_div.sv
`timescale 1ns / 1ps
// ============================================================================
// mpm_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module mpm_div #(
    parameter int NUM_W = 43,
    parameter int DEN_W = 14
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    // Partial remainder and a word that shifts dividend bits out and quotient bits in.
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++) begin : g_stage
            logic [DEN_W-1:0] w_rem_in;
            logic [NUM_W-1:0] w_nq_in;
            logic [DEN_W:0]   w_trial;
            logic             w_ge;
            logic [DEN_W:0]   w_diff;

            if (g == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_nq_in  = i_num;
            end else begin : g_next
                assign w_rem_in = r_rem[g-1];
                assign w_nq_in  = r_nq[g-1];
            end

            // Bring down the next dividend bit and try a subtract.
            assign w_trial = {w_rem_in, w_nq_in[NUM_W-1]};
            assign w_ge    = (w_trial >= {1'b0, i_den});
            assign w_diff  = w_trial - {1'b0, i_den};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_nq[g]  <= {w_nq_in[NUM_W-2:0], w_ge};
                end
            end
        end
    endgenerate

    assign o_quo = r_nq[NUM_W-1];
endmodule

// File: rtl/core/mpm_iter.sv
`timescale 1ns / 1ps
// ============================================================================
// mpm_iter
// One escape-time iteration in two stages: products, then update and check.
// ============================================================================
module mpm_iter (
    input  logic          i_clk,
    input  logic          i_en,
    input  mpm_pkg::t_iter i_st,
    output mpm_pkg::t_iter o_st
);
    import mpm_pkg::*;

    logic signed [63:0] r_pr;
    logic signed [63:0] r_pi;
    logic signed [63:0] r_px;
    t_iter              r_mid;
    t_iter              r_out;

    logic [63:0]        w_mag;
    logic               w_big;
    logic signed [63:0] w_dif;
    logic signed [37:0] w_nr;
    logic signed [37:0] w_ni;

    // First stage: the three products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr  <= i_st.zr * i_st.zr;
            r_pi  <= i_st.zi * i_st.zi;
            r_px  <= i_st.zr * i_st.zi;
            r_mid <= i_st;
        end
    end

    // Escape test on |z|^2 and the next z with floor shifts.
    always_comb begin
        w_mag = 64'(r_pr) + 64'(r_pi);
        w_big = (w_mag > ESC_BOUND);
        w_dif = r_pr - r_pi;
        w_nr  = 38'($signed(w_dif[63:28])) + 38'(r_mid.cr);
        w_ni  = 38'($signed(r_px[63:27])) + 38'(r_mid.ci);
    end

    // Second stage: saturated update.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.zr  <= sat_q(w_nr);
            r_out.zi  <= sat_q(w_ni);
            r_out.cr  <= r_mid.cr;
            r_out.ci  <= r_mid.ci;
            r_out.esc <= r_mid.esc | w_big;
        end
    end

    assign o_st = r_out;
endmodule

// File: rtl/core/mandelbrot_pixel_membership.sv
`timescale 1ns / 1ps
// ============================================================================
// mandelbrot_pixel_membership
// Escape-time Mandelbrot membership test, one pixel per cycle while the output is not held.
// ============================================================================
// Words enter on i_pix (column, row) and leave on o_res (out_column,
// out_row, inside_res) with a valid/ready handshake on each side. The pixel
// centre is mapped onto the window real -2.5..1.0, imaginary -1.0..1.0
// scaled by the image width and height, then z = z*z + c is run for
// MAX_ITERATIONS steps; inside_res is 1 when |z|^2 never exceeded 4.
// The user must write the dimensions on i_cfg_we/i_cfg_idx/i_cfg_data only
// while idle; the block itself does not enforce this. In order, data passes:
// one input stage, a divider that takes one quotient bit per stage, one
// mapping stage and two stages per iteration (multiply, then update).
// A new word may enter every cycle. When the receiver holds o_res.ready
// low with a result waiting, the whole pipeline holds and i_pix.ready
// drops; nothing is lost or repeated. Reset clears all valid bits, keeps
// i_pix.ready low and restores width 640 and height 480.
// ============================================================================
module mandelbrot_pixel_membership #(
    parameter int MAX_ITERATIONS = mpm_pkg::MAX_ITER_DEF,
    parameter int COORD_BITS     = mpm_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    mpm_pix_if.sink                    i_pix,
    mpm_res_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [mpm_pkg::DIM_W-1:0]  i_cfg_data
);
    import mpm_pkg::*;

    localparam int NUM_W = COORD_BITS + 1 + SPAN_W;
    localparam int DEN_W = DIM_W + 1;
    localparam int LAT   = NUM_W + 2 + 2 * MAX_ITERATIONS;

    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic                  r_vld [LAT];
    logic [PIX_W-1:0]      r_col [LAT];
    logic [PIX_W-1:0]      r_row [LAT];
    logic [NUM_W-1:0]      r_nre;
    logic [NUM_W-1:0]      r_nim;
    t_iter                 r_c;

    logic                  w_en;
    logic [COORD_BITS-1:0] w_col;
    logic [COORD_BITS-1:0] w_row;
    logic [DEN_W-1:0]      w_den_re;
    logic [DEN_W-1:0]      w_den_im;
    logic [NUM_W-1:0]      w_qre;
    logic [NUM_W-1:0]      w_qim;
    logic signed [NUM_W+1:0] w_sre;
    logic signed [NUM_W+1:0] w_sim;
    t_iter                 w_st [MAX_ITERATIONS+1];

    // Global advance: the pipeline moves unless a result is held.
    assign w_en        = !r_vld[LAT-1] || o_res.ready;
    assign i_pix.ready = w_en && i_rst_n;

    // Dimension registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // Divisors are twice the dimension, a zero dimension counting as one.
    assign w_den_re = {((r_width  == '0) ? DIM_W'(1) : r_width),  1'b0};
    assign w_den_im = {((r_height == '0) ? DIM_W'(1) : r_height), 1'b0};

    // Only the low coordinate bits take part.
    assign w_col = COORD_BITS'(i_pix.column);
    assign w_row = COORD_BITS'(i_pix.row);

    // Valid bits and echoed coordinates travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_pix.valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col[0] <= PIX_W'(w_col);
            r_row[0] <= PIX_W'(w_row);
            for (int k = 1; k < LAT; k++) begin
                r_col[k] <= r_col[k-1];
                r_row[k] <= r_row[k-1];
            end
        end
    end

    // Input stage: numerators (2*idx+1)*span at full width.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nre <= NUM_W'({w_col, 1'b1}) * NUM_W'(RE_SPAN);
            r_nim <= NUM_W'({w_row, 1'b1}) * NUM_W'(IM_SPAN);
        end
    end

    mpm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_re (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_nre),
        .i_den (w_den_re),
        .o_quo (w_qre)
    );

    mpm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_im (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_nim),
        .i_den (w_den_im),
        .o_quo (w_qim)
    );

    // Mapping stage: offset from the window edge, saturated at the top.
    assign w_sre = $signed({2'b00, w_qre}) + (NUM_W+2)'(RE_MIN);
    assign w_sim = $signed({2'b00, w_qim}) + (NUM_W+2)'(IM_MIN);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c.zr  <= '0;
            r_c.zi  <= '0;
            r_c.cr  <= (w_sre > (NUM_W+2)'(Q_MAX)) ? Q_MAX : w_sre[Q_W-1:0];
            r_c.ci  <= (w_sim > (NUM_W+2)'(Q_MAX)) ? Q_MAX : w_sim[Q_W-1:0];
            r_c.esc <= 1'b0;
        end
    end

    // Iteration chain.
    assign w_st[0] = r_c;

    genvar g;
    generate
        for (g = 0; g < MAX_ITERATIONS; g++) begin : g_iter
            mpm_iter u_iter (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_st  (w_st[g]),
                .o_st  (w_st[g+1])
            );
        end
    endgenerate

    // Result word.
    assign o_res.valid      = r_vld[LAT-1];
    assign o_res.out_column = r_col[LAT-1];
    assign o_res.out_row    = r_row[LAT-1];
    assign o_res.inside_res = !w_st[MAX_ITERATIONS].esc;
endmodule

// File: rtl/core/mpm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mpm_checker
// Port-level checks of the membership block, bound to its top level.
// ============================================================================
module mpm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_inside
);
    // A held result stays valid and keeps its inside flag on the output.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_inside))
        else $error("held result changed");

    // A stalled receiver stops intake.
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while result held");

    // No result right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With no result waiting, intake is open.
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");
endmodule

bind mandelbrot_pixel_membership mpm_checker u_mpm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_inside (o_res.inside_res)
);
